### rtl/core/assert_macros.svh
// Assertion macros shared by the sample FIFO modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define DSSF_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define DSSF_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) else $error(msg);

`endif

### rtl/core/dssf_pkg.sv
// Shared types and constants of the dual sound sample FIFO.
`default_nettype none

package dssf_pkg;

    localparam int FIFO_DEPTH_DEF = 32;
    localparam int DMA_LEVEL_DEF  = 16;
    localparam int PUSH_BYTES     = 4;
    localparam int LVL_W          = 6;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 8;

    // Request codes.
    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_CTRL = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TSEL_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TSEL_B = 2'd1;

    // Control register layout.
    localparam logic CTRL_OFFSET = 1'b1;
    localparam int   CLR_A_BIT   = 3;
    localparam int   CLR_B_BIT   = 7;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        channel;
        logic [31:0] sample_word;
        logic        timer_index;
        logic        reg_byte_offset;
        logic [7:0]  reg_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       sample_a;
        logic [7:0]       sample_b;
        logic             popped_a;
        logic             popped_b;
        logic             dma_request_a;
        logic             dma_request_b;
        logic             push_dropped;
        logic [LVL_W-1:0] level_a;
        logic [LVL_W-1:0] level_b;
    } t_out_item;

    // Command from the sequencer to one channel.
    typedef struct packed {
        logic       clear;
        logic       push;
        logic       pop;
        logic [7:0] data;
    } t_chan_cmd;

endpackage

`default_nettype wire

### rtl/core/dssf_ram.sv
// Byte-wide synchronous sample memory, one write port and one registered read port.
`default_nettype none

module dssf_ram #(
    parameter int DEPTH  = dssf_pkg::FIFO_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [7:0]        i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]             o_rdata
);

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/dssf_chan.sv
// One sample FIFO channel: pointers, fill count and its byte memory.
`default_nettype none

module dssf_chan #(
    parameter int FIFO_DEPTH = dssf_pkg::FIFO_DEPTH_DEF,
    parameter int PTR_W      = $clog2(FIFO_DEPTH),
    parameter int CNT_W      = $clog2(FIFO_DEPTH + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dssf_pkg::t_chan_cmd i_cmd,
    output logic [CNT_W-1:0]        o_level,
    output logic                    o_room,
    output logic [7:0]              o_rd_data,
    output logic                    o_rd_ok
);

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_MAX  = CNT_W'(FIFO_DEPTH - dssf_pkg::PUSH_BYTES);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(FIFO_DEPTH);

    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_rd_ok;
    logic             rd_en;

    assign rd_en = i_cmd.pop && (r_cnt != '0);

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_cmd.clear) begin
            n_wp  = '0;
            n_rp  = '0;
            n_cnt = '0;
        end else if (i_cmd.push) begin
            n_wp  = (r_wp == LAST_SLOT) ? '0 : r_wp + 1'b1;
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en) begin
            n_rp  = (r_rp == LAST_SLOT) ? '0 : r_rp + 1'b1;
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_cnt   <= n_cnt;
            r_rd_ok <= rd_en;
        end
    end

    dssf_ram #(
        .DEPTH  (FIFO_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_wp),
        .i_wdata (i_cmd.data),
        .i_re    (rd_en),
        .i_raddr (r_rp),
        .o_rdata (o_rd_data)
    );

    assign o_level = r_cnt;
    assign o_room  = (r_cnt <= ROOM_MAX);
    assign o_rd_ok = r_rd_ok;

`include "assert_macros.svh"

    `DSSF_ASSERT(a_level_bound, r_cnt <= FULL_CNT, "fill count beyond FIFO depth")
    `DSSF_ASSERT(a_no_push_full, !(i_cmd.push && r_cnt == FULL_CNT), "byte written to full FIFO")
    `DSSF_ASSERT_NEXT(a_empty_pop_holds, i_cmd.pop && r_cnt == '0 && !i_cmd.clear,
        $stable(r_cnt) && $stable(r_rp) && !r_rd_ok, "pop of empty FIFO changed state")

endmodule

`default_nettype wire

### rtl/core/dual_sound_sample_fifo.sv
// Top level of the dual sound sample FIFO: request sequencer and result register.
// A push word writes one byte per cycle in the push state, then goes to the finish state;
// a tick, control write, unused request or dropped push goes straight to the finish state.
// A new item is taken only in the idle state, so the next item waits until the result of
// the last one has been registered.
// Reset (synchronous, active low) empties both FIFOs and clears the timer selects;
// results cannot be stalled and are shown for one cycle on o_res_valid.
`default_nettype none

module dual_sound_sample_fifo #(
    parameter int FIFO_DEPTH = dssf_pkg::FIFO_DEPTH_DEF,
    parameter int DMA_LEVEL  = dssf_pkg::DMA_LEVEL_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire dssf_pkg::t_in_item             i_req,
    output logic                                o_res_valid,
    output dssf_pkg::t_out_item                 o_res,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [dssf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [dssf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] DMA_CNT = CNT_W'(DMA_LEVEL);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH,
        S_FINISH
    } t_state;

    t_state              r_state;
    dssf_pkg::t_in_item  r_in;
    logic [1:0]          r_byte_idx;
    logic                r_drop;
    logic                r_pop_a;
    logic                r_pop_b;
    logic                r_tsel_a;
    logic                r_tsel_b;
    logic                r_res_valid;
    dssf_pkg::t_out_item r_res;

    dssf_pkg::t_chan_cmd cmd_a, cmd_b;
    logic [CNT_W-1:0]    level_a, level_b;
    logic                room_a, room_b;
    logic [7:0]          rd_data_a, rd_data_b;
    logic                rd_ok_a, rd_ok_b;
    logic                accept;
    logic                is_tick, is_ctrl;
    logic [7:0]          push_byte;

    assign accept  = start && (r_state == S_IDLE);
    assign is_tick = accept && (i_req.req_type == dssf_pkg::REQ_TICK);
    assign is_ctrl = accept && (i_req.req_type == dssf_pkg::REQ_CTRL)
                     && (i_req.reg_byte_offset == dssf_pkg::CTRL_OFFSET);
    assign push_byte = 8'(r_in.sample_word >> {r_byte_idx, 3'b000});

    always_comb begin
        cmd_a.clear = is_ctrl && i_req.reg_byte[dssf_pkg::CLR_A_BIT];
        cmd_a.pop   = is_tick && (r_tsel_a == i_req.timer_index);
        cmd_a.push  = (r_state == S_PUSH) && !r_in.channel;
        cmd_a.data  = push_byte;
        cmd_b.clear = is_ctrl && i_req.reg_byte[dssf_pkg::CLR_B_BIT];
        cmd_b.pop   = is_tick && (r_tsel_b == i_req.timer_index);
        cmd_b.push  = (r_state == S_PUSH) && r_in.channel;
        cmd_b.data  = push_byte;
    end

    dssf_chan #(.FIFO_DEPTH(FIFO_DEPTH)) u_chan_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd_a),
        .o_level   (level_a),
        .o_room    (room_a),
        .o_rd_data (rd_data_a),
        .o_rd_ok   (rd_ok_a)
    );

    dssf_chan #(.FIFO_DEPTH(FIFO_DEPTH)) u_chan_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd_b),
        .o_level   (level_b),
        .o_room    (room_b),
        .o_rd_data (rd_data_b),
        .o_rd_ok   (rd_ok_b)
    );

    // Timer select registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tsel_a <= 1'b0;
            r_tsel_b <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == dssf_pkg::CFG_TSEL_A) begin
                r_tsel_a <= i_cfg_data[0];
            end
            if (i_cfg_index == dssf_pkg::CFG_TSEL_B) begin
                r_tsel_b <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_byte_idx  <= '0;
            r_drop      <= 1'b0;
            r_pop_a     <= 1'b0;
            r_pop_b     <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_in       <= i_req;
                        r_byte_idx <= '0;
                        r_drop     <= 1'b0;
                        r_pop_a    <= cmd_a.pop;
                        r_pop_b    <= cmd_b.pop;
                        r_state    <= S_FINISH;
                        if (i_req.req_type == dssf_pkg::REQ_PUSH) begin
                            if (i_req.channel ? room_b : room_a) begin
                                r_state <= S_PUSH;
                            end else begin
                                r_drop <= 1'b1;
                            end
                        end
                    end
                end
                S_PUSH: begin
                    r_byte_idx <= r_byte_idx + 1'b1;
                    if (r_byte_idx == 2'(dssf_pkg::PUSH_BYTES - 1)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    // Read data of a tick arrives here, and the levels have settled.
                    r_res_valid         <= 1'b1;
                    r_res.sample_a      <= (r_pop_a && rd_ok_a) ? rd_data_a : 8'h00;
                    r_res.sample_b      <= (r_pop_b && rd_ok_b) ? rd_data_b : 8'h00;
                    r_res.popped_a      <= r_pop_a;
                    r_res.popped_b      <= r_pop_b;
                    r_res.dma_request_a <= r_pop_a && (level_a <= DMA_CNT);
                    r_res.dma_request_b <= r_pop_b && (level_b <= DMA_CNT);
                    r_res.push_dropped  <= r_drop;
                    r_res.level_a       <= dssf_pkg::LVL_W'(level_a);
                    r_res.level_b       <= dssf_pkg::LVL_W'(level_b);
                    r_state             <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

`include "assert_macros.svh"

    `DSSF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not go busy")
    `DSSF_ASSERT_NEXT(a_finish_strobe, r_state == S_FINISH, o_res_valid,
        "no result after finish")
    `DSSF_ASSERT(a_drop_no_pop, !(o_res_valid && o_res.push_dropped
        && (o_res.popped_a || o_res.popped_b)), "dropped push reported a pop")

endmodule

`default_nettype wire

### bench/dual_sound_sample_fifo_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the dual sound sample FIFO: driver, monitor and byte-level predictor.
module dual_sound_sample_fifo_tb;
    import dssf_pkg::*;

    localparam logic [1:0]           REQ_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam int                   CYCLE_LIMIT  = 200000;
    localparam int                   SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_reg_write;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_in_item              i_req = '0;
    logic                  o_res_valid;
    t_out_item             o_res;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    dual_sound_sample_fifo u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: byte stores, pointers, fill levels and timer selects.
    logic [7:0]  fifo_mem [2][FIFO_DEPTH_DEF];
    int unsigned wr_ptr [2] = '{0, 0};
    int unsigned rd_ptr [2] = '{0, 0};
    int unsigned fill [2] = '{0, 0};
    logic        tsel [2] = '{1'b0, 1'b0};

    t_in_item    queued_requests [$];
    t_out_item   awaited_results [$];
    t_reg_write  queued_reg_writes [$];
    t_reg_write  next_write;
    int          items_queued = 0;
    int          items_accepted = 0;
    int          reg_writes_queued = 0;
    int          reg_writes_done = 0;
    int          mismatches = 0;
    int          idle_pct = 38;
    int          cycle_count = 0;
    bit          drain_hold = 1'b0;

    function automatic t_out_item fifo_step_result(input t_in_item it);
        t_out_item   res;
        logic [7:0]  smp [2];
        logic        popped [2];
        logic        dma [2];
        int unsigned ch;
        int unsigned k;
        res = '0;
        smp = '{8'h00, 8'h00};
        popped = '{1'b0, 1'b0};
        dma = '{1'b0, 1'b0};
        case (it.req_type)
            REQ_PUSH: begin
                ch = it.channel;
                if (fill[ch] + PUSH_BYTES > FIFO_DEPTH_DEF) begin
                    res.push_dropped = 1'b1;
                end else begin
                    for (k = 0; k < PUSH_BYTES; k++) begin
                        fifo_mem[ch][wr_ptr[ch]] = it.sample_word[8*k +: 8];
                        wr_ptr[ch] = (wr_ptr[ch] + 1) % FIFO_DEPTH_DEF;
                        fill[ch]++;
                    end
                end
            end
            REQ_TICK: begin
                for (ch = 0; ch < 2; ch++) begin
                    if (tsel[ch] == it.timer_index) begin
                        popped[ch] = 1'b1;
                        // An empty channel still counts as drained, with a zero sample.
                        if (fill[ch] != 0) begin
                            smp[ch] = fifo_mem[ch][rd_ptr[ch]];
                            rd_ptr[ch] = (rd_ptr[ch] + 1) % FIFO_DEPTH_DEF;
                            fill[ch]--;
                        end
                        dma[ch] = (fill[ch] <= DMA_LEVEL_DEF);
                    end
                end
            end
            REQ_CTRL: begin
                if (it.reg_byte_offset == CTRL_OFFSET) begin
                    for (ch = 0; ch < 2; ch++) begin
                        if (it.reg_byte[ch == 0 ? CLR_A_BIT : CLR_B_BIT]) begin
                            wr_ptr[ch] = 0;
                            rd_ptr[ch] = 0;
                            fill[ch] = 0;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.sample_a      = smp[0];
        res.sample_b      = smp[1];
        res.popped_a      = popped[0];
        res.popped_b      = popped[1];
        res.dma_request_a = dma[0];
        res.dma_request_b = dma[1];
        res.level_a       = LVL_W'(fill[0]);
        res.level_b       = LVL_W'(fill[1]);
        return res;
    endfunction

    // Driver: holds an item until it is taken, then maybe idles before the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                awaited_results.push_back(fifo_step_result(i_req));
                items_accepted++;
            end
            if (drain_hold && awaited_results.size() == 0) begin
                drain_hold = 1'b0;
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (queued_requests.size() != 0 && !drain_hold &&
                         $urandom_range(99) >= idle_pct) begin
                start <= 1'b1;
                i_req <= queued_requests.pop_front();
                // Now and then wait for the block to go quiet before the next item.
                if ($urandom_range(49) == 0) begin
                    drain_hold = 1'b1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Configuration channel: one register write at a time.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TSEL_A: tsel[0] = i_cfg_data[0];
                    CFG_TSEL_B: tsel[1] = i_cfg_data[0];
                    default: ;
                endcase
                reg_writes_done++;
            end
            if (i_cfg_valid && !o_cfg_ready) begin
                i_cfg_valid <= 1'b1;
            end else if (queued_reg_writes.size() != 0) begin
                next_write = queued_reg_writes.pop_front();
                i_cfg_valid <= 1'b1;
                i_cfg_index <= next_write.idx;
                i_cfg_data  <= next_write.data;
            end else begin
                i_cfg_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Monitor: every strobed result is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_res_valid) begin
            if (awaited_results.size() == 0) begin
                $error("result with no item outstanding: %p", o_res);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                check_field("sample_a", want.sample_a, o_res.sample_a);
                check_field("sample_b", want.sample_b, o_res.sample_b);
                check_field("popped_a", want.popped_a, o_res.popped_a);
                check_field("popped_b", want.popped_b, o_res.popped_b);
                check_field("dma_request_a", want.dma_request_a, o_res.dma_request_a);
                check_field("dma_request_b", want.dma_request_b, o_res.dma_request_b);
                check_field("push_dropped", want.push_dropped, o_res.push_dropped);
                check_field("level_a", want.level_a, o_res.level_a);
                check_field("level_b", want.level_b, o_res.level_b);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_request(input logic [1:0] req, input logic ch, input logic [31:0] word,
                               input logic tmr, input logic off, input logic [7:0] cbyte);
        t_in_item it;
        it.req_type        = req;
        it.channel         = ch;
        it.sample_word     = word;
        it.timer_index     = tmr;
        it.reg_byte_offset = off;
        it.reg_byte        = cbyte;
        queued_requests.push_back(it);
        items_queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        t_reg_write w;
        w.idx  = idx;
        w.data = data;
        queued_reg_writes.push_back(w);
        reg_writes_queued++;
        while (reg_writes_done < reg_writes_queued) @(posedge i_clk);
    endtask

    task automatic wait_quiet();
        while (items_accepted < items_queued || awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Push rate swings between low and high so the levels sweep from empty to full.
    task automatic add_random_requests(input int count);
        int          n;
        int          roll;
        int          push_pct;
        logic [1:0]  req;
        for (n = 0; n < count; n++) begin
            push_pct = ((n / 40) % 2) ? 42 : 14;
            roll = $urandom_range(99);
            if (roll < push_pct)           req = REQ_PUSH;
            else if (roll < 91)            req = REQ_TICK;
            else if (roll < 96)            req = REQ_CTRL;
            else                           req = REQ_UNUSED;
            add_request(req, 1'($urandom_range(1)), $urandom, 1'($urandom_range(1)),
                        1'($urandom_range(1)), 8'($urandom_range(255)));
        end
    endtask

    initial begin
        int n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Both channels on timer 0; upper data bits must be ignored.
        write_reg(CFG_TSEL_A, 8'hFE);
        write_reg(CFG_TSEL_B, 8'h00);
        add_request(REQ_CTRL, 1'b0, 32'h0, 1'b0, CTRL_OFFSET, 8'h00);
        add_request(REQ_TICK, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1, 8'hFF);
        add_request(REQ_TICK, 1'b0, 32'h0, 1'b1, 1'b0, 8'h00);
        add_request(REQ_PUSH, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 8'h00);
        add_request(REQ_PUSH, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF);
        for (n = 0; n < 6; n++) begin
            add_request(REQ_PUSH, 1'b0, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                        8'($urandom_range(255)));
        end
        // Channel A is now full, so this word cannot fit.
        add_request(REQ_PUSH, 1'b0, 32'h1234_5678, 1'b0, 1'b0, 8'h00);
        add_request(REQ_PUSH, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00);
        add_request(REQ_TICK, 1'b0, 32'h0, 1'b0, 1'b0, 8'h00);
        add_request(REQ_TICK, 1'b1, 32'h0, 1'b0, 1'b1, 8'h88);
        add_request(REQ_CTRL, 1'b0, 32'h0, 1'b0, 1'b0, 8'hFF);
        add_request(REQ_CTRL, 1'b0, 32'h0, 1'b0, CTRL_OFFSET, 8'h08);
        add_request(REQ_TICK, 1'b0, 32'h0, 1'b0, 1'b0, 8'h00);
        add_request(REQ_PUSH, 1'b0, 32'h80C0_E0F1, 1'b0, 1'b0, 8'h00);
        add_request(REQ_CTRL, 1'b1, 32'h0, 1'b1, CTRL_OFFSET, 8'h80);
        add_request(REQ_PUSH, 1'b1, 32'h7F3F_1F0F, 1'b0, 1'b0, 8'h00);
        add_request(REQ_CTRL, 1'b0, 32'h0, 1'b0, CTRL_OFFSET, 8'h88);
        add_request(REQ_UNUSED, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF);
        add_request(REQ_PUSH, 1'b1, 32'hDEAD_BEEF, 1'b0, 1'b0, 8'h00);
        add_request(REQ_TICK, 1'b1, 32'h0, 1'b0, 1'b0, 8'h00);
        wait_quiet();

        write_reg(CFG_TSEL_A, 8'h01);
        write_reg(CFG_TSEL_B, 8'hA4);
        write_reg(CFG_SPARE_LO, 8'hFF);
        add_random_requests(350);
        wait_quiet();

        write_reg(CFG_TSEL_A, 8'h00);
        write_reg(CFG_TSEL_B, 8'h01);
        add_random_requests(300);
        wait_quiet();

        idle_pct = 54;
        write_reg(CFG_TSEL_A, 8'hFF);
        write_reg(CFG_TSEL_B, 8'h5B);
        add_random_requests(350);
        wait_quiet();

        write_reg(CFG_TSEL_A, 8'h00);
        write_reg(CFG_TSEL_B, 8'h00);
        write_reg(CFG_SPARE_HI, 8'hFF);
        add_random_requests(300);
        wait_quiet();

        idle_pct = 0;
        write_reg(CFG_TSEL_A, 8'h01);
        write_reg(CFG_TSEL_B, 8'h00);
        add_random_requests(450);
        wait_quiet();

        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
